@@ hw/rtl/assert_macros.svh @@
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds on every clock edge outside reset
`define RBSE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition in one cycle implies a condition in the next
`define RBSE_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

@@ hw/rtl/rbse_pkg.sv @@
// types and constants of the ray box slab entry block
package rbse_pkg;

    localparam int COORD_W    = 32;
    localparam int FRAC_B     = 16;
    localparam int NUM_AXES   = 3;
    localparam int NUM_DIVS   = 2 * NUM_AXES;
    localparam int DIV_STAGES = COORD_W + FRAC_B;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic [COORD_W-1:0]        mag_t;
    typedef logic [2:0]                cfg_idx_t;

    localparam cfg_idx_t CFG_BOX_MIN_X = 3'd0;
    localparam cfg_idx_t CFG_BOX_MIN_Y = 3'd1;
    localparam cfg_idx_t CFG_BOX_MIN_Z = 3'd2;
    localparam cfg_idx_t CFG_BOX_MAX_X = 3'd3;
    localparam cfg_idx_t CFG_BOX_MAX_Y = 3'd4;
    localparam cfg_idx_t CFG_BOX_MAX_Z = 3'd5;

    localparam coord_t COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam coord_t COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    typedef struct packed {
        coord_t start_x;
        coord_t start_y;
        coord_t start_z;
        coord_t end_x;
        coord_t end_y;
        coord_t end_z;
    } ray_t;

    typedef struct packed {
        coord_t entry_x;
        coord_t entry_y;
        coord_t entry_z;
        logic   hit;
    } hit_t;

    // per-ray data that rides alongside the dividers
    typedef struct packed {
        coord_t [NUM_AXES-1:0] start;
        mag_t   [NUM_AXES-1:0] dmag;
        logic   [NUM_AXES-1:0] dneg;
        logic   [NUM_AXES-1:0] par;
        logic                  pmiss;
    } side_t;

endpackage

@@ hw/rtl/rbse_prep.sv @@
// input stage: directions, slab numerators and parallel-ray test
module rbse_prep (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        en,
    input  logic                                        vld_in,
    input  rbse_pkg::ray_t                              ray,
    input  rbse_pkg::coord_t [rbse_pkg::NUM_AXES-1:0]   box_min,
    input  rbse_pkg::coord_t [rbse_pkg::NUM_AXES-1:0]   box_max,
    output logic                                        vld_out,
    output rbse_pkg::side_t                             side,
    output rbse_pkg::mag_t   [rbse_pkg::NUM_DIVS-1:0]   div_num,
    output logic             [rbse_pkg::NUM_DIVS-1:0]   div_neg
);

    localparam int W = rbse_pkg::COORD_W;

    logic                                      vld_reg;
    rbse_pkg::side_t                           side_reg, side_next;
    rbse_pkg::mag_t [rbse_pkg::NUM_DIVS-1:0]   num_reg, num_next;
    logic [rbse_pkg::NUM_DIVS-1:0]             neg_reg, neg_next;

    logic signed [W:0] diff_d, diff_1, diff_2;
    logic [W:0]        inv_d, inv_1, inv_2;
    rbse_pkg::coord_t  s, e, lo, hi;

    always_comb
    begin
        side_next = '0;
        num_next  = '0;
        neg_next  = '0;
        s = '0; e = '0; lo = '0; hi = '0;
        diff_d = '0; diff_1 = '0; diff_2 = '0;
        inv_d = '0; inv_1 = '0; inv_2 = '0;
        for (int a = 0; a < rbse_pkg::NUM_AXES; a++)
        begin
            case (a)
                0:
                begin
                    s = ray.start_x;
                    e = ray.end_x;
                end
                1:
                begin
                    s = ray.start_y;
                    e = ray.end_y;
                end
                default:
                begin
                    s = ray.start_z;
                    e = ray.end_z;
                end
            endcase
            lo = box_min[a];
            hi = box_max[a];
            diff_d = $signed({e[W-1], e}) - $signed({s[W-1], s});
            diff_1 = $signed({lo[W-1], lo}) - $signed({s[W-1], s});
            diff_2 = $signed({hi[W-1], hi}) - $signed({s[W-1], s});
            inv_d  = ~diff_d + 1'b1;
            inv_1  = ~diff_1 + 1'b1;
            inv_2  = ~diff_2 + 1'b1;
            side_next.start[a] = s;
            side_next.dneg[a]  = diff_d[W];
            side_next.dmag[a]  = diff_d[W] ? inv_d[W-1:0] : diff_d[W-1:0];
            side_next.par[a]   = (diff_d == '0);
            if ((diff_d == '0) && (($signed(s) < $signed(lo)) || ($signed(s) > $signed(hi))))
            begin
                side_next.pmiss = 1'b1;
            end
            num_next[2*a]   = diff_1[W] ? inv_1[W-1:0] : diff_1[W-1:0];
            num_next[2*a+1] = diff_2[W] ? inv_2[W-1:0] : diff_2[W-1:0];
            neg_next[2*a]   = diff_1[W] ^ diff_d[W];
            neg_next[2*a+1] = diff_2[W] ^ diff_d[W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= vld_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg <= side_next;
            num_reg  <= num_next;
            neg_reg  <= neg_next;
        end
    end

    assign vld_out = vld_reg;
    assign side    = side_reg;
    assign div_num = num_reg;
    assign div_neg = neg_reg;

endmodule

@@ hw/rtl/rbse_div.sv @@
// pipelined restoring divider, one quotient bit per stage, saturating
module rbse_div (
    input  logic             clk,
    input  logic             en,
    input  rbse_pkg::mag_t   num,
    input  rbse_pkg::mag_t   den,
    input  logic             neg,
    output rbse_pkg::coord_t t
);

    localparam int W  = rbse_pkg::COORD_W;
    localparam int NB = rbse_pkg::DIV_STAGES;

    logic [W:0]   rem_reg [NB];
    logic [W-1:0] quo_reg [NB];
    logic [W-1:0] num_reg [NB];
    logic [W-1:0] den_reg [NB];
    logic         ovf_reg [NB];
    logic         neg_reg [NB];

    for (genvar k = 0; k < NB; k++)
    begin : g_stage
        logic [W:0]   rem_in, shifted, rem_next;
        logic [W-1:0] quo_in, num_in, den_in, quo_next;
        logic         ovf_in, neg_in, qbit;

        if (k == 0)
        begin : g_first
            assign rem_in = '0;
            assign quo_in = '0;
            assign num_in = num;
            assign den_in = den;
            assign ovf_in = 1'b0;
            assign neg_in = neg;
        end
        else
        begin : g_rest
            assign rem_in = rem_reg[k-1];
            assign quo_in = quo_reg[k-1];
            assign num_in = num_reg[k-1];
            assign den_in = den_reg[k-1];
            assign ovf_in = ovf_reg[k-1];
            assign neg_in = neg_reg[k-1];
        end

        always_comb
        begin
            // numerator bits run out after W steps, the fraction bits are zero
            shifted = {rem_in[W-1:0], num_in[W-1]};
            qbit    = (shifted >= {1'b0, den_in});
            rem_next = qbit ? (shifted - {1'b0, den_in}) : shifted;
            quo_next = {quo_in[W-2:0], qbit};
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= rem_next;
                quo_reg[k] <= quo_next;
                num_reg[k] <= {num_in[W-2:0], 1'b0};
                den_reg[k] <= den_in;
                ovf_reg[k] <= ovf_in | quo_in[W-1];
                neg_reg[k] <= neg_in;
            end
        end
    end

    logic         sat;
    logic [W-1:0] q_fin;

    assign q_fin = quo_reg[NB-1];
    assign sat   = ovf_reg[NB-1] | q_fin[W-1];

    always_comb
    begin
        if (sat)
        begin
            t = neg_reg[NB-1] ? rbse_pkg::COORD_MIN : rbse_pkg::COORD_MAX;
        end
        else
        begin
            t = neg_reg[NB-1] ? rbse_pkg::coord_t'(~q_fin + 1'b1) : rbse_pkg::coord_t'(q_fin);
        end
    end

endmodule

@@ hw/rtl/rbse_slab.sv @@
// slab ordering and entry/exit reduction over the three axes
module rbse_slab (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        en,
    input  logic                                        vld_in,
    input  rbse_pkg::side_t                             side_in,
    input  rbse_pkg::coord_t [rbse_pkg::NUM_DIVS-1:0]   t,
    output logic                                        vld_out,
    output rbse_pkg::side_t                             side_out,
    output rbse_pkg::coord_t                            tmin,
    output logic                                        hit
);

    localparam int NA = rbse_pkg::NUM_AXES;

    // order stage
    logic                        o_vld_reg;
    rbse_pkg::side_t             o_side_reg;
    rbse_pkg::coord_t [NA-1:0]   o_lo_reg, o_lo_next;
    rbse_pkg::coord_t [NA-1:0]   o_hi_reg, o_hi_next;

    // reduce stage
    logic                        r_vld_reg;
    rbse_pkg::side_t             r_side_reg;
    rbse_pkg::coord_t            r_tmin_reg, r_tmin_next, tmax_c;
    logic                        r_hit_reg, r_hit_next;

    always_comb
    begin
        for (int a = 0; a < NA; a++)
        begin
            if (side_in.par[a])
            begin
                o_lo_next[a] = '0;
                o_hi_next[a] = rbse_pkg::COORD_MAX;
            end
            else if ($signed(t[2*a]) > $signed(t[2*a+1]))
            begin
                o_lo_next[a] = t[2*a+1];
                o_hi_next[a] = t[2*a];
            end
            else
            begin
                o_lo_next[a] = t[2*a];
                o_hi_next[a] = t[2*a+1];
            end
        end
    end

    always_comb
    begin
        r_tmin_next = '0;
        tmax_c      = rbse_pkg::COORD_MAX;
        for (int a = 0; a < NA; a++)
        begin
            if ($signed(o_lo_reg[a]) > $signed(r_tmin_next))
            begin
                r_tmin_next = o_lo_reg[a];
            end
            if ($signed(o_hi_reg[a]) < $signed(tmax_c))
            begin
                tmax_c = o_hi_reg[a];
            end
        end
        r_hit_next = !o_side_reg.pmiss && !($signed(r_tmin_next) > $signed(tmax_c));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_vld_reg <= 1'b0;
            r_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            o_vld_reg <= vld_in;
            r_vld_reg <= o_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            o_side_reg <= side_in;
            o_lo_reg   <= o_lo_next;
            o_hi_reg   <= o_hi_next;
            r_side_reg <= o_side_reg;
            r_tmin_reg <= r_tmin_next;
            r_hit_reg  <= r_hit_next;
        end
    end

    assign vld_out  = r_vld_reg;
    assign side_out = r_side_reg;
    assign tmin     = r_tmin_reg;
    assign hit      = r_hit_reg;

endmodule

@@ hw/rtl/rbse_entry.sv @@
// entry point: start plus direction times tmin, truncated and saturated
module rbse_entry (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             vld_in,
    input  rbse_pkg::side_t  side,
    input  rbse_pkg::coord_t tmin,
    input  logic             hit_in,
    output logic             vld_out,
    output rbse_pkg::hit_t   result
);

    localparam int W  = rbse_pkg::COORD_W;
    localparam int F  = rbse_pkg::FRAC_B;
    localparam int NA = rbse_pkg::NUM_AXES;
    localparam int SW = 2 * W + 2;

    logic                              m_vld_reg;
    logic [2*W-1:0]                    m_prod_reg [NA];
    rbse_pkg::coord_t [NA-1:0]         m_start_reg;
    logic [NA-1:0]                     m_dneg_reg;
    logic                              m_hit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            m_vld_reg <= vld_in;
        end
    end

    // tmin is never negative, so the product is unsigned
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int a = 0; a < NA; a++)
            begin
                m_prod_reg[a] <= {{W{1'b0}}, side.dmag[a]} * {{W{1'b0}}, tmin};
            end
            m_start_reg <= side.start;
            m_dneg_reg  <= side.dneg;
            m_hit_reg   <= hit_in;
        end
    end

    localparam logic signed [SW-1:0] SUM_MAX = $signed({{(W+2){1'b0}}, rbse_pkg::COORD_MAX});
    localparam logic signed [SW-1:0] SUM_MIN = $signed({{(W+2){1'b1}}, rbse_pkg::COORD_MIN});

    rbse_pkg::coord_t [NA-1:0] coord;
    logic [2*W-1:0]            qv;
    logic signed [SW-1:0]      se, qe, sum;

    always_comb
    begin
        qv = '0; se = '0; qe = '0; sum = '0;
        for (int a = 0; a < NA; a++)
        begin
            qv  = m_prod_reg[a] >> F;
            se  = $signed({{(W+2){m_start_reg[a][W-1]}}, m_start_reg[a]});
            qe  = $signed({2'b00, qv});
            sum = m_dneg_reg[a] ? (se - qe) : (se + qe);
            if (!m_hit_reg)
            begin
                coord[a] = '0;
            end
            else if (sum > SUM_MAX)
            begin
                coord[a] = rbse_pkg::COORD_MAX;
            end
            else if (sum < SUM_MIN)
            begin
                coord[a] = rbse_pkg::COORD_MIN;
            end
            else
            begin
                coord[a] = sum[W-1:0];
            end
        end
        result.entry_x = coord[0];
        result.entry_y = coord[1];
        result.entry_z = coord[2];
        result.hit     = m_hit_reg;
    end

    assign vld_out = m_vld_reg;

endmodule

@@ hw/rtl/ray_box_slab_entry.sv @@
// top level of the ray against axis-aligned box slab test
// One ray segment word is taken per cycle and one result word leaves per cycle, in order,
// while the output is not stalled; values are Q16.16 in 32 bits. Stages: one input stage,
// the 48-stage restoring divider pipeline (one quotient bit per stage, six dividers side by
// side), slab ordering, entry/exit reduction, the multiplier stage and the output register.
// A stall at the output freezes the whole pipeline; config writes are taken at once and
// belong only in idle time.
module ray_box_slab_entry (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  rbse_pkg::ray_t      in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output rbse_pkg::hit_t      out_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  rbse_pkg::cfg_idx_t  cfg_index,
    input  rbse_pkg::coord_t    cfg_data
);

    localparam int NB = rbse_pkg::DIV_STAGES;
    localparam int NA = rbse_pkg::NUM_AXES;
    localparam int ND = rbse_pkg::NUM_DIVS;

    logic en;

    // box registers
    rbse_pkg::coord_t [NA-1:0] box_min_reg, box_max_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_min_reg <= '0;
            box_max_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                rbse_pkg::CFG_BOX_MIN_X: box_min_reg[0] <= cfg_data;
                rbse_pkg::CFG_BOX_MIN_Y: box_min_reg[1] <= cfg_data;
                rbse_pkg::CFG_BOX_MIN_Z: box_min_reg[2] <= cfg_data;
                rbse_pkg::CFG_BOX_MAX_X: box_max_reg[0] <= cfg_data;
                rbse_pkg::CFG_BOX_MAX_Y: box_max_reg[1] <= cfg_data;
                rbse_pkg::CFG_BOX_MAX_Z: box_max_reg[2] <= cfg_data;
                default: ;
            endcase
        end
    end

    assign cfg_ready = 1'b1;

    // input stage
    logic                              vld_p;
    rbse_pkg::side_t                   side_p;
    rbse_pkg::mag_t   [ND-1:0]         div_num;
    logic             [ND-1:0]         div_neg;

    rbse_prep u_prep (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .vld_in  (in_valid),
        .ray     (in_data),
        .box_min (box_min_reg),
        .box_max (box_max_reg),
        .vld_out (vld_p),
        .side    (side_p),
        .div_num (div_num),
        .div_neg (div_neg)
    );

    // dividers and the matching delay line
    rbse_pkg::coord_t [ND-1:0] t_div;
    logic                      vld_d_reg [NB];
    rbse_pkg::side_t           side_d_reg [NB];

    for (genvar i = 0; i < ND; i++)
    begin : g_div
        rbse_div u_div (
            .clk (clk),
            .en  (en),
            .num (div_num[i]),
            .den (side_p.dmag[i/2]),
            .neg (div_neg[i]),
            .t   (t_div[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NB; k++)
            begin
                vld_d_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            vld_d_reg[0] <= vld_p;
            for (int k = 1; k < NB; k++)
            begin
                vld_d_reg[k] <= vld_d_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_d_reg[0] <= side_p;
            for (int k = 1; k < NB; k++)
            begin
                side_d_reg[k] <= side_d_reg[k-1];
            end
        end
    end

    // slab reduction
    logic              vld_s, hit_s;
    rbse_pkg::side_t   side_s;
    rbse_pkg::coord_t  tmin_s;

    rbse_slab u_slab (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .vld_in   (vld_d_reg[NB-1]),
        .side_in  (side_d_reg[NB-1]),
        .t        (t_div),
        .vld_out  (vld_s),
        .side_out (side_s),
        .tmin     (tmin_s),
        .hit      (hit_s)
    );

    // entry point
    logic            vld_e;
    rbse_pkg::hit_t  res_e;

    rbse_entry u_entry (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .vld_in  (vld_s),
        .side    (side_s),
        .tmin    (tmin_s),
        .hit_in  (hit_s),
        .vld_out (vld_e),
        .result  (res_e)
    );

    // output register
    logic            out_vld_reg;
    rbse_pkg::hit_t  out_data_reg;

    assign en = !out_vld_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            out_vld_reg <= vld_e;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_data_reg <= res_e;
        end
    end

    assign in_ready  = en;
    assign out_valid = out_vld_reg;
    assign out_data  = out_data_reg;

endmodule

@@ hw/rtl/rbse_checker.sv @@
// port-level checks for the ray box slab entry block, bound to the top level
`include "assert_macros.svh"

module rbse_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input rbse_pkg::hit_t     out_data,
    input logic               cfg_ready
);

    // a held result word stays put
    `RBSE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "output word changed while stalled")

    // a miss reports the origin as entry point
    `RBSE_ASSERT(a_miss_zero, !(out_valid && !out_data.hit) || (out_data.entry_x == '0 && out_data.entry_y == '0 && out_data.entry_z == '0), "miss with nonzero entry point")

    // input stalls exactly when the output register is held
    `RBSE_ASSERT(a_stall_link, in_ready == (!out_valid || out_ready), "input ready does not follow output stall")

    // config port never pushes back
    `RBSE_ASSERT(a_cfg_ready, cfg_ready, "config port not ready")

endmodule

bind ray_box_slab_entry rbse_checker u_rbse_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_ready (cfg_ready)
);

@@ verif/ray_box_slab_entry_tb.sv @@
// testbench for the ray against axis-aligned box slab entry block
module ray_box_slab_entry_tb;

    localparam int LATENCY   = rbse_pkg::DIV_STAGES + 5;
    localparam int MAX_CYC   = 2000000;
    localparam logic signed [63:0] TMAX_V = 64'sd2147483647;
    localparam logic signed [63:0] TMIN_V = -64'sd2147483648;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    rbse_pkg::ray_t     in_data;
    logic               out_valid;
    logic               out_ready;
    rbse_pkg::hit_t     out_data;
    logic               cfg_valid;
    logic               cfg_ready;
    rbse_pkg::cfg_idx_t cfg_index;
    rbse_pkg::coord_t   cfg_data;

    rbse_pkg::coord_t box_lo [3];
    rbse_pkg::coord_t box_hi [3];
    rbse_pkg::hit_t   pending_hits [$];
    int     errors;
    int     rays_sent;
    int     hits_seen;
    int     cycles;
    bit     hold_long;
    bit     rx_idle_en;

    ray_box_slab_entry uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // fixed-point slab parameter, rounded toward zero and saturated
    function automatic logic signed [63:0] slab_t(logic signed [63:0] num,
                                                 logic signed [63:0] den);
        logic signed [127:0] q;
        q = ($signed({{64{num[63]}}, num}) <<< rbse_pkg::FRAC_B)
            / $signed({{64{den[63]}}, den});
        if (q > TMAX_V) return TMAX_V;
        if (q < TMIN_V) return TMIN_V;
        return q[63:0];
    endfunction

    function automatic rbse_pkg::hit_t predict_entry(rbse_pkg::ray_t r);
        logic signed [63:0] s [3];
        logic signed [63:0] d [3];
        logic signed [63:0] t1, t2, tx, tmin, tmax;
        logic signed [127:0] prod, e;
        bit ok;
        rbse_pkg::hit_t h;
        s[0] = r.start_x; s[1] = r.start_y; s[2] = r.start_z;
        d[0] = 64'(r.end_x) - s[0];
        d[1] = 64'(r.end_y) - s[1];
        d[2] = 64'(r.end_z) - s[2];
        tmin = 0;
        tmax = TMAX_V;
        ok = 1'b1;
        for (int a = 0; a < 3; a++)
        begin
            if (!ok) break;
            if (d[a] == 0)
            begin
                if (s[a] < 64'(box_lo[a]) || s[a] > 64'(box_hi[a])) ok = 1'b0;
            end
            else
            begin
                t1 = slab_t(64'(box_lo[a]) - s[a], d[a]);
                t2 = slab_t(64'(box_hi[a]) - s[a], d[a]);
                if (t1 > t2)
                begin
                    tx = t1; t1 = t2; t2 = tx;
                end
                if (t1 > tmin) tmin = t1;
                if (t2 < tmax) tmax = t2;
                if (tmin > tmax) ok = 1'b0;
            end
        end
        h = '0;
        if (!ok) return h;
        for (int a = 0; a < 3; a++)
        begin
            prod = $signed({{64{d[a][63]}}, d[a]}) * $signed({64'd0, tmin});
            // truncate toward zero
            if (prod < 0) prod = -((-prod) >>> rbse_pkg::FRAC_B);
            else prod = prod >>> rbse_pkg::FRAC_B;
            e = prod + $signed({{64{s[a][63]}}, s[a]});
            if (e > TMAX_V) e = TMAX_V;
            if (e < TMIN_V) e = TMIN_V;
            if (a == 0) h.entry_x = e[31:0];
            else if (a == 1) h.entry_y = e[31:0];
            else h.entry_z = e[31:0];
        end
        h.hit = 1'b1;
        return h;
    endfunction

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > MAX_CYC)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // result checker
    always @(posedge clk)
    begin
        rbse_pkg::hit_t want;
        if (rst_n && out_valid && out_ready)
        begin
            hits_seen++;
            if (pending_hits.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result word %h", $time, out_data);
            end
            else
            begin
                want = pending_hits.pop_front();
                if (out_data.hit !== want.hit)
                begin
                    errors++;
                    $display("%0t: hit exp %b got %b", $time, want.hit, out_data.hit);
                end
                if (out_data.entry_x !== want.entry_x)
                begin
                    errors++;
                    $display("%0t: entry_x exp %h got %h", $time, want.entry_x,
                             out_data.entry_x);
                end
                if (out_data.entry_y !== want.entry_y)
                begin
                    errors++;
                    $display("%0t: entry_y exp %h got %h", $time, want.entry_y,
                             out_data.entry_y);
                end
                if (out_data.entry_z !== want.entry_z)
                begin
                    errors++;
                    $display("%0t: entry_z exp %h got %h", $time, want.entry_z,
                             out_data.entry_z);
                end
            end
        end
    end

    // receiver: random stalls, or one long hold-off on request
    initial
    begin
        int wait_n;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_long)
            begin
                wait_n = 400;
                hold_long = 1'b0;
            end
            else
            begin
                wait_n = rx_idle_en ? $urandom_range(0, 10) : 0;
            end
            if (wait_n > 0)
            begin
                out_ready <= 1'b0;
                repeat (wait_n) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
        end
    end

    // valid stays high after the word is taken, the next call or drain moves it on
    task automatic send_ray(rbse_pkg::ray_t r, bit gaps);
        int gap;
        gap = gaps ? $urandom_range(0, 10) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= r;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        pending_hits = {pending_hits, predict_entry(r)};
        rays_sent++;
    endtask

    // valid stays high after the write, the caller drops it
    task automatic write_reg(rbse_pkg::cfg_idx_t idx, rbse_pkg::coord_t val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        if (idx <= rbse_pkg::CFG_BOX_MAX_Z)
        begin
            if (idx < rbse_pkg::CFG_BOX_MAX_X) box_lo[idx] = val;
            else box_hi[idx - rbse_pkg::CFG_BOX_MAX_X] = val;
        end
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        while (pending_hits.size() != 0) @(posedge clk);
        repeat (LATENCY + 5) @(posedge clk);
    endtask

    task automatic set_box(rbse_pkg::coord_t lx, rbse_pkg::coord_t ly, rbse_pkg::coord_t lz,
                           rbse_pkg::coord_t hx, rbse_pkg::coord_t hy, rbse_pkg::coord_t hz);
        drain();
        write_reg(rbse_pkg::CFG_BOX_MIN_X, lx);
        write_reg(rbse_pkg::CFG_BOX_MIN_Y, ly);
        write_reg(rbse_pkg::CFG_BOX_MIN_Z, lz);
        write_reg(rbse_pkg::CFG_BOX_MAX_X, hx);
        write_reg(rbse_pkg::CFG_BOX_MAX_Y, hy);
        write_reg(rbse_pkg::CFG_BOX_MAX_Z, hz);
        cfg_valid <= 1'b0;
    endtask

    function automatic rbse_pkg::coord_t rand_coord(int mode);
        case (mode)
            0: return $urandom();
            1: return $signed($urandom_range(0, 32'h000A_0000)) - 32'sh0005_0000;
            2: return $urandom_range(0, 1) ? rbse_pkg::COORD_MAX : rbse_pkg::COORD_MIN;
            default: return $signed($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000;
        endcase
    endfunction

    function automatic rbse_pkg::ray_t make_ray(rbse_pkg::coord_t sx, rbse_pkg::coord_t sy,
                                                rbse_pkg::coord_t sz, rbse_pkg::coord_t ex,
                                                rbse_pkg::coord_t ey, rbse_pkg::coord_t ez);
        rbse_pkg::ray_t r;
        r.start_x = sx; r.start_y = sy; r.start_z = sz;
        r.end_x = ex; r.end_y = ey; r.end_z = ez;
        return r;
    endfunction

    task automatic test_directed;
        rbse_pkg::coord_t one;
        rbse_pkg::coord_t cmax;
        rbse_pkg::coord_t cmin;
        one  = 32'sh0001_0000;
        cmax = rbse_pkg::COORD_MAX;
        cmin = rbse_pkg::COORD_MIN;
        // reset box is a single point at the origin
        send_ray(make_ray(0, 0, 0, 0, 0, 0), 0);
        set_box(-one, -one, -one, one, one, one);
        send_ray(make_ray(-3 * one, 0, 0, 3 * one, 0, 0), 0);
        send_ray(make_ray(0, 0, 0, one, one, one), 0);                 // starts inside
        send_ray(make_ray(3 * one, 0, 0, 4 * one, 0, 0), 0);           // points away
        send_ray(make_ray(2 * one, 2 * one, 0, 2 * one, 3 * one, 0), 0); // parallel miss
        send_ray(make_ray(0, -5 * one, 0, 0, -4 * one, 0), 0);         // parallel inside
        send_ray(make_ray(cmin, cmin, cmin, cmax, cmax, cmax), 0);
        send_ray(make_ray(cmax, 0, 0, cmin, 0, 0), 0);
        send_ray(make_ray(-3 * one, 0, 0, -3 * one + 1, 0, 0), 0);     // division saturates
        send_ray(make_ray(-3 * one, 7, -5, 3 * one, 13, 11), 0);       // rounding
        send_ray(make_ray(-one - 1, one, 0, cmin, one, 0), 0);
        set_box(cmin, cmin, cmin, cmax, cmax, cmax);
        send_ray(make_ray(cmax, cmin, 0, cmax - 1, cmin + 1, 0), 0);
        send_ray(make_ray(0, 0, 0, cmax, cmin, 1), 0);
        // inverted box
        set_box(one, one, one, -one, -one, -one);
        send_ray(make_ray(0, 0, 0, 0, 0, 0), 0);
        send_ray(make_ray(-3 * one, 0, 0, 3 * one, one, one), 0);
        send_ray(make_ray(cmin, cmax, 0, cmax, cmin, one), 0);
        // index beyond the last register is ignored
        drain();
        write_reg(rbse_pkg::cfg_idx_t'(rbse_pkg::CFG_BOX_MAX_Z + 1), 32'hDEAD_BEEF);
        write_reg(rbse_pkg::cfg_idx_t'(rbse_pkg::CFG_BOX_MAX_Z + 2), 32'h1234_5678);
        cfg_valid <= 1'b0;
        send_ray(make_ray(-3 * one, 0, 0, 3 * one, one, one), 0);
    endtask

    task automatic test_random(int count, int mode);
        rbse_pkg::coord_t sx, sy, sz;
        for (int i = 0; i < count; i++)
        begin
            sx = rand_coord(mode); sy = rand_coord(mode); sz = rand_coord(mode);
            if ($urandom_range(0, 7) == 0)
                send_ray(make_ray(sx, sy, sz, sx, rand_coord(mode), sz), 1);
            else
                send_ray(make_ray(sx, sy, sz, rand_coord(mode), rand_coord(mode),
                                  rand_coord(mode)), $urandom_range(0, 3) != 0);
        end
    endtask

    task automatic test_random_boxes;
        rbse_pkg::coord_t lo, hi;
        int mode;
        for (int p = 0; p < 10; p++)
        begin
            mode = p % 4;
            lo = rand_coord(mode);
            hi = rand_coord(mode);
            if (p % 5 != 4 && lo > hi)
            begin
                rbse_pkg::coord_t tmp;
                tmp = lo; lo = hi; hi = tmp;
            end
            set_box(lo, rand_coord(mode) - 32'sh0010_0000, lo,
                    hi, rand_coord(mode) + 32'sh0010_0000, hi);
            rx_idle_en = (p % 3 != 0);
            test_random(140, (p % 2) ? 1 : mode);
        end
    endtask

    task automatic test_backpressure;
        set_box(-32'sh0004_0000, -32'sh0004_0000, -32'sh0004_0000,
                32'sh0004_0000, 32'sh0004_0000, 32'sh0004_0000);
        hold_long = 1'b1;
        for (int i = 0; i < 80; i++)
            send_ray(make_ray(rand_coord(1), rand_coord(1), rand_coord(1),
                              rand_coord(1), rand_coord(1), rand_coord(1)), 0);
    endtask

    initial
    begin
        errors = 0; rays_sent = 0; hits_seen = 0; cycles = 0;
        hold_long = 1'b0; rx_idle_en = 1'b1;
        for (int a = 0; a < 3; a++)
        begin
            box_lo[a] = '0; box_hi[a] = '0;
        end
        rst_n = 1'b0;
        in_valid = 1'b0; in_data = '0;
        cfg_valid = 1'b0; cfg_index = rbse_pkg::CFG_BOX_MIN_X; cfg_data = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_backpressure();
        test_random_boxes();
        drain();
        $display("rays sent %0d, results checked %0d, over directed, stalled and random boxes",
                 rays_sent, hits_seen);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
